// ----- rtl/png_scanline_unfilter_macros.svh -----
// Assertion helpers for the scanline unfilter block.
// Each macro expects clk and rst_n in scope.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// Same-cycle implication, inactive during reset
`define PSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive during reset
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psu_pkg.sv -----
package psu_pkg;

  // Field and register widths
  localparam int BPP_W       = 4;
  localparam int ROW_BYTES_W = 13;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ROW_BYTES = 4096;
  localparam int DEF_MAX_BPP       = 8;

  // Register reset values
  localparam logic [BPP_W-1:0]       BPP_RESET       = 4'd1;
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 13'd4096;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_BPP = 1'b0,
    REG_ROW = 1'b1
  } reg_idx_t;

  // Filter type of the current row
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_t;

endpackage

// ----- rtl/png_scanline_unfilter.sv -----
// PNG scanline reconstruction. Takes the inflated stream one byte per cycle
// while in_ready is high: the first byte of every row is its filter type and
// gives no result, every other byte gives one reconstructed byte, marked on
// the last byte of the row. Throughput is one item per cycle when the output
// is not stalled; a data byte passes the work stage and then the output
// register, a filter byte is absorbed at accept. The row above lives in a
// line store of MAX_ROW_BYTES bytes with one read and one write port, read at
// accept and rewritten when the byte leaves the work stage. The line store is
// not cleared: rows after the first must not be longer than the first row of
// the image. Set bytes_per_pixel (1..8) and row_bytes (1..4096) over the APB
// port while no item is in flight; registers sit at byte address 0 and 4.
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES       = DEF_MAX_ROW_BYTES,
  parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BPP
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(MAX_ROW_BYTES);
  localparam int CW = (PW + 1 > ROW_BYTES_W) ? PW + 1 : ROW_BYTES_W;
  localparam int HW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

  // Paeth predictor: pick the neighbor closest to a + b - c
  function automatic logic [7:0] paeth_pred(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic signed [9:0] p;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [7:0]        res;
    p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
    pa = p - $signed({2'b00, a});
    pb = p - $signed({2'b00, b});
    pc = p - $signed({2'b00, c});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) res = a;
    else if (pb <= pc)        res = b;
    else                      res = c;
    return res;
  endfunction

  // Configuration registers
  logic [BPP_W-1:0]       bpp_r;
  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  // Row tracking
  logic          awaiting_r;
  logic          first_row_r;
  filter_t       kind_r;
  logic [PW-1:0] pos_r;

  // Accept-side decode
  logic             in_fire;
  logic             start_filter;
  logic             acc_data;
  logic [BPP_W-1:0] bpp_eff;
  logic [CW-1:0]    rb_eff;
  logic             acc_last;
  logic             acc_left;
  logic [HW-1:0]    acc_hidx;
  filter_t          new_kind;

  // Work stage
  logic          s_valid_r;
  logic [7:0]    s_byte_r;
  logic [PW-1:0] s_pos_r;
  filter_t       s_kind_r;
  logic          s_first_r;
  logic          s_last_r;
  logic          s_left_r;
  logic [HW-1:0] s_hidx_r;
  logic [7:0]    rd_r;
  logic          s_move;

  // Line store and histories, newest first
  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] left_hist_r [MAX_BYTES_PER_PIXEL];
  logic [7:0] up_hist_r [MAX_BYTES_PER_PIXEL];

  // Reconstruction
  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [7:0] pred;
  logic [7:0] recon;

  // Output register
  logic o_valid_r;
  out_t o_data_r;

  // APB access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_BPP: prdata = {{(32 - BPP_W){1'b0}}, bpp_r};
      REG_ROW: prdata = {{(32 - ROW_BYTES_W){1'b0}}, row_bytes_r};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= BPP_RESET;
      row_bytes_r <= ROW_BYTES_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BPP: bpp_r       <= pwdata[BPP_W-1:0];
        REG_ROW: row_bytes_r <= pwdata[ROW_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage drains into the output register when it is free
  assign s_move   = s_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s_valid_r || s_move;
  assign in_fire  = in_valid && in_ready;

  // Decode the incoming item against the row state
  always_comb begin
    start_filter = in_data.image_start || awaiting_r;
    acc_data     = in_fire && !start_filter;

    if (bpp_r == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
      bpp_eff = BPP_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      bpp_eff = bpp_r;
    end

    if (row_bytes_r == '0) begin
      rb_eff = CW'(1);
    end else if (CW'(row_bytes_r) > CW'(MAX_ROW_BYTES)) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CW'(row_bytes_r);
    end

    acc_last = (CW'(pos_r) + CW'(1)) >= rb_eff;
    acc_left = CW'(pos_r) >= CW'(bpp_eff);
    acc_hidx = HW'(bpp_eff - BPP_W'(1));

    if (in_data.data_byte <= 8'(FILT_PAETH)) begin
      new_kind = filter_t'(in_data.data_byte[2:0]);
    end else begin
      new_kind = FILT_BAD;
    end
  end

  // Advance row tracking at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      first_row_r <= 1'b1;
      kind_r      <= FILT_NONE;
      pos_r       <= '0;
    end else if (in_fire) begin
      if (start_filter) begin
        kind_r     <= new_kind;
        awaiting_r <= 1'b0;
        pos_r      <= '0;
        if (in_data.image_start) begin
          first_row_r <= 1'b1;
        end
      end else if (acc_last) begin
        awaiting_r  <= 1'b1;
        pos_r       <= '0;
        first_row_r <= 1'b0;
      end else begin
        pos_r <= pos_r + PW'(1);
      end
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= acc_data;
    end
  end

  // Capture stage payload
  always_ff @(posedge clk) begin
    if (acc_data) begin
      s_byte_r  <= in_data.data_byte;
      s_pos_r   <= pos_r;
      s_kind_r  <= kind_r;
      s_first_r <= first_row_r;
      s_last_r  <= acc_last;
      s_left_r  <= acc_left;
      s_hidx_r  <= acc_hidx;
    end
  end

  // Line store: read the byte above at accept, write back when the item leaves
  always_ff @(posedge clk) begin
    if (s_move) begin
      line_mem[s_pos_r] <= recon;
    end
    if (acc_data) begin
      rd_r <= line_mem[pos_r];
    end
  end

  // Reconstruct from left, above and upper-left
  always_comb begin
    nb_b = s_first_r ? 8'd0 : rd_r;
    nb_a = s_left_r ? left_hist_r[s_hidx_r] : 8'd0;
    nb_c = s_left_r ? up_hist_r[s_hidx_r] : 8'd0;
    case (s_kind_r)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = nb_a;
      FILT_UP:    pred = nb_b;
      FILT_AVG:   pred = 8'((9'(nb_a) + 9'(nb_b)) >> 1);
      FILT_PAETH: pred = paeth_pred(nb_a, nb_b, nb_c);
      default:    pred = 8'd0;
    endcase
    recon = s_byte_r + pred;
  end

  // Shift histories; entries before the row start are masked by s_left_r
  always_ff @(posedge clk) begin
    if (s_move) begin
      for (int i = MAX_BYTES_PER_PIXEL - 1; i > 0; i--) begin
        left_hist_r[i] <= left_hist_r[i-1];
        up_hist_r[i]   <= up_hist_r[i-1];
      end
      left_hist_r[0] <= recon;
      up_hist_r[0]   <= nb_b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s_move) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_move) begin
      o_data_r.pixel_byte <= (s_kind_r == FILT_BAD) ? 8'd0 : recon;
      o_data_r.row_end    <= s_last_r;
      o_data_r.bad_filter <= (s_kind_r == FILT_BAD);
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  // Checks
  `PSU_ASSERT_NOW(a_bad_is_zero, out_valid && out_data.bad_filter, out_data.pixel_byte == 8'd0, "bad filter result carries data")
  `PSU_ASSERT_NOW(a_full_blocks, s_valid_r && o_valid_r && !out_ready, !in_ready, "accepted into a full stage")
  `PSU_ASSERT_NEXT(a_last_rearms, acc_data && acc_last, awaiting_r && pos_r == '0, "row end did not rearm filter byte")
  `PSU_ASSERT_NEXT(a_image_start, in_fire && in_data.image_start, first_row_r && !awaiting_r && !s_valid_r, "image start not taken as filter byte")

endmodule

// ----- sim/tb_png_scanline_unfilter.sv -----
`timescale 1ns / 100ps

module tb_png_scanline_unfilter;
  import psu_pkg::*;

  localparam int ROW_CAP  = DEF_MAX_ROW_BYTES;
  localparam int HIST     = DEF_MAX_BPP;
  // Filter type byte outside the defined set
  localparam logic [7:0] KIND_UNKNOWN = 8'hFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  png_scanline_unfilter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Unfilter state mirrored on the testbench side
  logic [BPP_W-1:0]       bpp_reg;
  logic [ROW_BYTES_W-1:0] row_reg;
  logic [7:0]             above_row [ROW_CAP];
  logic [7:0]             left_hist [HIST];
  logic [7:0]             diag_hist [HIST];
  int unsigned            col;
  filter_t                row_filter;
  bit                     want_filter;
  bit                     top_row;
  int unsigned            stored_len;

  out_t pending_pixels [$];
  int   errors = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   rows_seen = 0;
  int   flagged_seen = 0;
  int   formats_used = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  function automatic void clear_row_state();
    for (int i = 0; i < HIST; i++) begin
      left_hist[i] = '0;
      diag_hist[i] = '0;
    end
    col = 0;
    want_filter = 1'b1;
  endfunction

  function automatic int unsigned eff_row_len();
    if (row_reg == 0) return 1;
    if (row_reg > ROW_CAP) return ROW_CAP;
    return row_reg;
  endfunction

  function automatic int paeth_pick(input int a, input int b, input int c);
    int est, da, db, dc;
    est = a + b - c;
    da = (est > a) ? est - a : a - est;
    db = (est > b) ? est - b : b - est;
    dc = (est > c) ? est - c : c - est;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Advance the unfilter state by one byte; return 1 when a pixel byte comes out
  function automatic bit unfilter_byte(input in_t item, output out_t res);
    int span, a, b, c, pred, v;
    bit last;
    res = '0;
    if (item.image_start) begin
      clear_row_state();
      top_row = 1'b1;
    end
    if (want_filter) begin
      row_filter = (item.data_byte <= 8'(FILT_PAETH)) ? filter_t'(item.data_byte[2:0])
                                                      : FILT_BAD;
      want_filter = 1'b0;
      col = 0;
      return 1'b0;
    end
    span = (bpp_reg == 0) ? 1 : ((bpp_reg > HIST) ? HIST : int'(bpp_reg));
    b = top_row ? 0 : int'(above_row[col]);
    if (col >= span) begin
      a = left_hist[span-1];
      c = diag_hist[span-1];
    end else begin
      a = 0;
      c = 0;
    end
    case (row_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) >> 1;
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 0;
    endcase
    v = (int'(item.data_byte) + pred) & 255;
    // Unknown filter rows still store the raw byte
    above_row[col] = v[7:0];
    if (col + 1 > stored_len) stored_len = col + 1;
    for (int i = HIST - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      diag_hist[i] = diag_hist[i-1];
    end
    left_hist[0] = v[7:0];
    diag_hist[0] = b[7:0];
    last = (col + 1 >= eff_row_len());
    res.pixel_byte = (row_filter == FILT_BAD) ? 8'd0 : v[7:0];
    res.bad_filter = (row_filter == FILT_BAD);
    res.row_end = last;
    if (last) begin
      clear_row_state();
      top_row = 1'b0;
    end else begin
      col = col + 1;
    end
    return 1'b1;
  endfunction

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each accepted pixel byte with the oldest expectation
  always @(negedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.row_end) rows_seen++;
      if (out_data.bad_filter) flagged_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected item %h, nothing pending", $time, out_data);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_byte !== want.pixel_byte) begin
          errors++;
          if (errors <= 30)
            $display("%0t: pixel_byte expected %h actual %h", $time,
                     want.pixel_byte, out_data.pixel_byte);
        end
        if (out_data.row_end !== want.row_end) begin
          errors++;
          if (errors <= 30)
            $display("%0t: row_end expected %b actual %b", $time,
                     want.row_end, out_data.row_end);
        end
        if (out_data.bad_filter !== want.bad_filter) begin
          errors++;
          if (errors <= 30)
            $display("%0t: bad_filter expected %b actual %b", $time,
                     want.bad_filter, out_data.bad_filter);
        end
      end
    end
  end

  // Send one item, idling first at random; predict on accept
  task automatic send_item(input in_t item);
    bit   taken;
    out_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    if (unfilter_byte(item, res)) pending_pixels.push_back(res);
  endtask

  // Hold input, wait for every pending pixel byte, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask, got;
    mask = (idx == REG_BPP) ? 32'((1 << BPP_W) - 1) : 32'((1 << ROW_BYTES_W) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    case (idx)
      REG_BPP: bpp_reg = value[BPP_W-1:0];
      default: row_reg = value[ROW_BYTES_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (value & mask)) begin
      errors++;
      $display("%0t: register %s readback expected %h actual %h", $time,
               idx.name(), value & mask, got & mask);
    end
    @(posedge clk);
  endtask

  task automatic set_format(input int unsigned bpp, input int unsigned len);
    write_reg(REG_BPP, bpp);
    write_reg(REG_ROW, len);
    formats_used++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // One filter byte and three data bytes
  task automatic send_row(input logic [7:0] kind, input bit img, input logic [23:0] bytes);
    in_t item;
    item.data_byte = kind;
    item.image_start = img;
    send_item(item);
    for (int i = 0; i < 3; i++) begin
      item.data_byte = bytes[23 - 8*i -: 8];
      item.image_start = 1'b0;
      send_item(item);
    end
  endtask

  // Rows of random content; the first item opens a new image, noise_pct adds
  // image starts at random points and pause_at drains mid-stream
  task automatic random_stream(input int count, input int noise_pct, input int pause_at);
    in_t item;
    bit  img;
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) drain_results();
      img = (k == 0) || ($urandom_range(0, 99) < noise_pct);
      // Never read line store entries that were not written since reset
      if (want_filter && !img && !top_row && eff_row_len() > stored_len) img = 1'b1;
      item.image_start = img;
      if (img || want_filter)
        item.data_byte = ($urandom_range(0, 99) < 85) ?
                         8'($urandom_range(FILT_NONE, FILT_PAETH)) :
                         8'($urandom_range(0, 255));
      else
        item.data_byte = 8'($urandom_range(0, 255));
      send_item(item);
    end
    drain_results();
  endtask

  task automatic test_register_access();
    write_reg(REG_BPP, 32'd0);
    write_reg(REG_BPP, 32'd15);
    write_reg(REG_BPP, 32'd8);
    write_reg(REG_ROW, 32'd0);
    write_reg(REG_ROW, 32'd8191);
    write_reg(REG_ROW, 32'd4096);
  endtask

  task automatic test_each_filter();
    set_idling(32, 76);
    set_format(1, 3);
    send_row({5'd0, FILT_NONE}, 1'b1, 24'h00FF80);
    send_row({5'd0, FILT_SUB}, 1'b0, 24'hFF01FF);
    send_row({5'd0, FILT_UP}, 1'b0, 24'h01FF00);
    send_row({5'd0, FILT_AVG}, 1'b0, 24'hFFFF01);
    send_row({5'd0, FILT_PAETH}, 1'b0, 24'h7F80FF);
    send_row(KIND_UNKNOWN, 1'b0, 24'h123456);
    drain_results();
  endtask

  task automatic test_random_streams();
    int unsigned bpp_set [8] = '{1, 8, 0, 15, 3, 2, 4, 6};
    int unsigned len_set [8] = '{1, 16, 5, 7, 0, 13, 33, 9};
    for (int p = 0; p < 8; p++) begin
      if (p < 3) set_idling(32, 76);
      else if (p < 6) set_idling(76, 32);
      else set_idling(0, 0);
      set_format(bpp_set[p], len_set[p]);
      random_stream(45, 4, (p == 4) ? 25 : -1);
    end
  endtask

  // Widest setting: clamped pixel size and row length over a partial first row
  task automatic test_full_row();
    set_idling(0, 0);
    set_format(15, 8191);
    random_stream(40, 0, -1);
  endtask

  initial begin
    bpp_reg = BPP_RESET;
    row_reg = ROW_BYTES_RESET;
    clear_row_state();
    row_filter = FILT_NONE;
    top_row = 1'b1;
    stored_len = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_each_filter();
    test_random_streams();
    test_full_row();
    repeat (10) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d pixel bytes never arrived", $time, pending_pixels.size());
    end
    $display("Sent %0d items over %0d formats; got %0d pixel bytes in %0d rows,",
             items_sent, formats_used, results_seen, rows_seen);
    $display("%0d flagged bad filter, under three stall patterns", flagged_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
